// ----- rtl/rrfp_pkg.sv -----
// Package for the round robin free register picker.
// Holds widths, action codes, register indexes, reset values and the pointer advance rule.
// No dependencies.
`default_nettype none

package rrfp_pkg;

  // Widths of register numbers, the busy mask and the configuration index.
  localparam int RegW    = 5;
  localparam int MaskW   = 32;
  localparam int CfgIdxW = 3;
  localparam int ActW    = 2;

  // Number of registers that exist; a register number at or above it counts as busy.
  localparam int NumRegs = 32;

  // A scan visits at most this many positions.
  localparam int ScanLimit = 32;
  localparam int CntW      = $clog2(ScanLimit);

  typedef logic [RegW-1:0]    reg_num_t;
  typedef logic [MaskW-1:0]   mask_t;
  typedef logic [CfgIdxW-1:0] cfg_idx_t;
  typedef logic [ActW-1:0]    action_t;

  // Action codes.
  localparam action_t ActStart = 2'd0;
  localparam action_t ActFixed = 2'd1;
  localparam action_t ActFloat = 2'd2;

  // Configuration register indexes.
  localparam cfg_idx_t CfgFixFirst   = 3'd0;
  localparam cfg_idx_t CfgFixLast    = 3'd1;
  localparam cfg_idx_t CfgFixRestart = 3'd2;
  localparam cfg_idx_t CfgHeldBack   = 3'd3;
  localparam cfg_idx_t CfgFixFail    = 3'd4;
  localparam cfg_idx_t CfgFltFirst   = 3'd5;
  localparam cfg_idx_t CfgFltLast    = 3'd6;

  // Reset values of the configuration registers.
  localparam reg_num_t RstFixFirst   = 5'd1;
  localparam reg_num_t RstFixLast    = 5'd31;
  localparam reg_num_t RstFixRestart = 5'd8;
  localparam reg_num_t RstHeldBack   = 5'd15;
  localparam reg_num_t RstFixFail    = 5'd1;
  localparam reg_num_t RstFltFirst   = 5'd0;
  localparam reg_num_t RstFltLast    = 5'd31;

  // The floating pointer is reloaded with this value by a start action.
  localparam reg_num_t FltRestart = 5'd1;

  // Successor of a pointer within a class ring: wrap to first at last, else step by one.
  function automatic reg_num_t advance(reg_num_t p, reg_num_t first, reg_num_t last);
    reg_num_t nxt;
    if (p == last) begin
      nxt = first;
    end else begin
      nxt = p + reg_num_t'(1);
    end
    return nxt;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/round_robin_free_register_picker_top.sv -----
// Top level of the round robin free register picker.
// Depends on rrfp_pkg for widths, codes, reset values and the advance rule.
//
//   Channel   | Handshake              | Payload
//   ----------+------------------------+-----------------------------------
//   request   | start / busy           | action_i, busy_mask_i
//   result    | result_valid_o strobe  | chosen_reg_o, failed_o
//   config    | cfg_we_i               | cfg_idx_i, cfg_wdata_i
//
// A request is taken while the block is idle. A pick then scans one register position per cycle,
// from the class pointer up to the first free register, or round the ring when none is
// free (at most ScanLimit positions), and the result strobes for one cycle after the
// last scan cycle.
// A start action reloads both pointers in the cycle it is taken and gives no result.
// Reset is asynchronous and active low; it loads the default register numbering.
// The receiver cannot stall: each result is shown for exactly one cycle.
`default_nettype none

module round_robin_free_register_picker_top (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  wire                  start,
  output logic                 busy,
  input  wire rrfp_pkg::action_t  action_i,
  input  wire rrfp_pkg::mask_t    busy_mask_i,
  output logic                 result_valid_o,
  output rrfp_pkg::reg_num_t   chosen_reg_o,
  output logic                 failed_o,
  input  wire                  cfg_we_i,
  input  wire rrfp_pkg::cfg_idx_t cfg_idx_i,
  input  wire rrfp_pkg::reg_num_t cfg_wdata_i
);

  import rrfp_pkg::*;

  localparam logic StIdle = 1'b0;
  localparam logic StScan = 1'b1;

  // Configuration registers.
  reg_num_t fix_first_q, fix_last_q, fix_restart_q, held_back_q, fix_fail_q;
  reg_num_t flt_first_q, flt_last_q;

  // Pointers and scan state.
  reg_num_t fix_ptr_q, fix_ptr_d;
  reg_num_t flt_ptr_q, flt_ptr_d;
  logic     state_q, state_d;
  logic     is_fix_q, is_fix_d;
  mask_t    mask_q, mask_d;
  reg_num_t pos_q, pos_d;
  reg_num_t begin_q, begin_d;
  logic [CntW-1:0] cnt_q, cnt_d;

  // Result registers.
  logic     res_valid_q, res_valid_d;
  reg_num_t res_reg_q, res_reg_d;
  logic     res_fail_q, res_fail_d;

  logic     accept;
  logic     pos_free, held_free, pos_ok, last_step;
  reg_num_t nxt_pos;

  assign accept = start && !busy;
  assign busy   = (state_q == StScan);

  // Configuration writes; an index beyond the list is ignored.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fix_first_q   <= RstFixFirst;
      fix_last_q    <= RstFixLast;
      fix_restart_q <= RstFixRestart;
      held_back_q   <= RstHeldBack;
      fix_fail_q    <= RstFixFail;
      flt_first_q   <= RstFltFirst;
      flt_last_q    <= RstFltLast;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CfgFixFirst:   fix_first_q   <= cfg_wdata_i;
        CfgFixLast:    fix_last_q    <= cfg_wdata_i;
        CfgFixRestart: fix_restart_q <= cfg_wdata_i;
        CfgHeldBack:   held_back_q   <= cfg_wdata_i;
        CfgFixFail:    fix_fail_q    <= cfg_wdata_i;
        CfgFltFirst:   flt_first_q   <= cfg_wdata_i;
        CfgFltLast:    flt_last_q    <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // Test of the current scan position and of the held-back register.
  assign pos_free  = ((7'(pos_q) < 7'(NumRegs)) && !mask_q[pos_q]);
  assign held_free = ((7'(held_back_q) < 7'(NumRegs)) && !mask_q[held_back_q]);
  assign pos_ok    = pos_free && !(is_fix_q && (pos_q == held_back_q));
  assign nxt_pos   = is_fix_q ? advance(pos_q, fix_first_q, fix_last_q)
                              : advance(pos_q, flt_first_q, flt_last_q);
  assign last_step = (nxt_pos == begin_q) || (cnt_q == CntW'(ScanLimit - 1));

  // Request decode and one scan step per cycle.
  always_comb begin
    state_d     = state_q;
    fix_ptr_d   = fix_ptr_q;
    flt_ptr_d   = flt_ptr_q;
    is_fix_d    = is_fix_q;
    mask_d      = mask_q;
    pos_d       = pos_q;
    begin_d     = begin_q;
    cnt_d       = cnt_q;
    res_valid_d = 1'b0;
    res_reg_d   = res_reg_q;
    res_fail_d  = res_fail_q;

    case (state_q)
      StIdle: begin
        if (accept) begin
          case (action_i)
            ActStart: begin
              fix_ptr_d = fix_restart_q;
              flt_ptr_d = FltRestart;
            end
            ActFixed: begin
              state_d  = StScan;
              is_fix_d = 1'b1;
              mask_d   = busy_mask_i;
              pos_d    = fix_ptr_q;
              begin_d  = fix_ptr_q;
              cnt_d    = '0;
            end
            ActFloat: begin
              state_d  = StScan;
              is_fix_d = 1'b0;
              mask_d   = busy_mask_i;
              pos_d    = flt_ptr_q;
              begin_d  = flt_ptr_q;
              cnt_d    = '0;
            end
            default: ;
          endcase
        end
      end
      StScan: begin
        if (pos_ok) begin
          // Free register found: pick it and move the class pointer past it.
          state_d     = StIdle;
          res_valid_d = 1'b1;
          res_reg_d   = pos_q;
          res_fail_d  = 1'b0;
          if (is_fix_q) begin
            fix_ptr_d = nxt_pos;
          end else begin
            flt_ptr_d = nxt_pos;
          end
        end else if (last_step) begin
          // Ring exhausted: fall back to the held-back register or report failure.
          state_d     = StIdle;
          res_valid_d = 1'b1;
          if (is_fix_q && held_free) begin
            res_reg_d  = held_back_q;
            res_fail_d = 1'b0;
          end else if (is_fix_q) begin
            res_reg_d  = fix_fail_q;
            res_fail_d = 1'b1;
          end else begin
            res_reg_d  = '0;
            res_fail_d = 1'b1;
          end
        end else begin
          pos_d = nxt_pos;
          cnt_d = cnt_q + CntW'(1);
        end
      end
      default: state_d = StIdle;
    endcase
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      fix_ptr_q   <= RstFixFirst;
      flt_ptr_q   <= RstFltFirst;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      fix_ptr_q   <= fix_ptr_d;
      flt_ptr_q   <= flt_ptr_d;
      res_valid_q <= res_valid_d;
    end
  end

  // Payload registers of the scan and the result.
  always_ff @(posedge clk_i) begin
    is_fix_q  <= is_fix_d;
    mask_q    <= mask_d;
    pos_q     <= pos_d;
    begin_q   <= begin_d;
    cnt_q     <= cnt_d;
    res_reg_q <= res_reg_d;
    res_fail_q <= res_fail_d;
  end

  assign result_valid_o = res_valid_q;
  assign chosen_reg_o   = res_reg_q;
  assign failed_o       = res_fail_q;

  // A result strobe lasts one cycle and only follows a finished scan.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |=> !result_valid_o)
    else $error("result strobe longer than one cycle");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> !busy)
    else $error("result shown while a scan is still running");

  // A successful pick never names a register that the mask marks busy.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && !failed_o) |-> !mask_q[chosen_reg_o])
    else $error("picked register is busy");

  // The scanner only starts on an accepted request.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(busy) |-> $past(start))
    else $error("scan started without a request");

endmodule

`default_nettype wire

// ----- tb/tb_round_robin_free_register_picker_top.sv -----
`timescale 1ns / 100ps
// Self-checking testbench for the round robin free register picker top level.
// Depends on rrfp_pkg; predicts each pick in a small scoreboard class and checks every strobe.

import rrfp_pkg::*;

// Expected outcome of one pick request.
typedef struct packed {
  reg_num_t chosen;
  logic     failed;
} pick_t;

// Shadow copy of the register numbering and both pointers, plus the queue of pending picks.
class reg_pick_scoreboard;
  reg_num_t    fix_first;
  reg_num_t    fix_last;
  reg_num_t    fix_restart;
  reg_num_t    held_back;
  reg_num_t    fix_fail;
  reg_num_t    flt_first;
  reg_num_t    flt_last;
  reg_num_t    fixed_ptr;
  reg_num_t    float_ptr;
  pick_t       expected_picks[$];
  int unsigned failures;

  function new();
    fix_first   = RstFixFirst;
    fix_last    = RstFixLast;
    fix_restart = RstFixRestart;
    held_back   = RstHeldBack;
    fix_fail    = RstFixFail;
    flt_first   = RstFltFirst;
    flt_last    = RstFltLast;
    fixed_ptr   = RstFixFirst;
    float_ptr   = RstFltFirst;
    failures    = 0;
  endfunction

  // Mirror a configuration write; pointers are left alone.
  function void write_reg(cfg_idx_t idx, reg_num_t val);
    case (idx)
      CfgFixFirst:   fix_first   = val;
      CfgFixLast:    fix_last    = val;
      CfgFixRestart: fix_restart = val;
      CfgHeldBack:   held_back   = val;
      CfgFixFail:    fix_fail    = val;
      CfgFltFirst:   flt_first   = val;
      CfgFltLast:    flt_last    = val;
      default: ;
    endcase
  endfunction

  // A register is free when it exists and its mask bit is clear.
  function bit is_free(reg_num_t r, mask_t mask);
    return (int'(r) < NumRegs) && !mask[r];
  endfunction

  // Step round the ring, wrapping from the last register back to the first.
  function reg_num_t ring_next(reg_num_t p, reg_num_t first, reg_num_t last);
    reg_num_t nxt;
    if (p == last) begin
      nxt = first;
    end else begin
      nxt = reg_num_t'(p + 1'b1);
    end
    return nxt;
  endfunction

  // Scan from the pointer for the first free register; the pointer only moves on success.
  function bit find_free(inout reg_num_t ptr, input reg_num_t first, input reg_num_t last,
                         input mask_t mask, input bit skip_held, output reg_num_t pick);
    reg_num_t origin;
    reg_num_t p;
    reg_num_t nxt;
    bit       ok;
    origin = ptr;
    p      = origin;
    pick   = '0;
    for (int i = 0; i < ScanLimit; i++) begin
      ok  = is_free(p, mask) && !(skip_held && (p == held_back));
      nxt = ring_next(p, first, last);
      if (ok) begin
        pick = p;
        ptr  = nxt;
        return 1'b1;
      end
      // A pointer off the ring may never be met again; the scan limit then ends the walk.
      if (nxt == origin) break;
      p = nxt;
    end
    return 1'b0;
  endfunction

  // Work out the outcome of an accepted item and queue it when it yields a result.
  function void predict_pick(action_t act, mask_t mask);
    pick_t    pick;
    reg_num_t r;
    case (act)
      ActStart: begin
        fixed_ptr = fix_restart;
        float_ptr = FltRestart;
      end
      ActFixed: begin
        if (find_free(fixed_ptr, fix_first, fix_last, mask, 1'b1, r)) begin
          pick = '{chosen: r, failed: 1'b0};
        end else if (is_free(held_back, mask)) begin
          // The held-back register is the last resort of the fixed class.
          pick = '{chosen: held_back, failed: 1'b0};
        end else begin
          pick = '{chosen: fix_fail, failed: 1'b1};
        end
        expected_picks.push_back(pick);
      end
      ActFloat: begin
        if (find_free(float_ptr, flt_first, flt_last, mask, 1'b0, r)) begin
          pick = '{chosen: r, failed: 1'b0};
        end else begin
          pick = '{chosen: '0, failed: 1'b1};
        end
        expected_picks.push_back(pick);
      end
      default: ;
    endcase
  endfunction

  function void note_failure(string msg);
    failures++;
    if (failures <= 10) $display("%0t: mismatch: %s", $time, msg);
  endfunction

  // Compare a strobed result with the oldest pending pick.
  function void check_pick(reg_num_t chosen, logic failed);
    pick_t want;
    if (expected_picks.size() == 0) begin
      note_failure($sformatf("unexpected result chosen=%0d failed=%0b", chosen, failed));
    end else begin
      want = expected_picks.pop_front();
      if (chosen !== want.chosen || failed !== want.failed) begin
        note_failure($sformatf("chosen expected %0d actual %0d, failed expected %0b actual %0b",
                               want.chosen, chosen, want.failed, failed));
      end
    end
  endfunction

  function int pending();
    return expected_picks.size();
  endfunction
endclass

module tb_round_robin_free_register_picker_top;

  // A start action has no result, so the block is given this long to go quiet.
  localparam int      DrainCycles = 48;
  localparam action_t ActUnused   = 2'd3;

  logic     clk_i       = 1'b0;
  logic     rst_ni      = 1'b0;
  logic     start       = 1'b0;
  logic     busy;
  action_t  action_i    = ActStart;
  mask_t    busy_mask_i = '0;
  logic     result_valid_o;
  reg_num_t chosen_reg_o;
  logic     failed_o;
  logic     cfg_we_i    = 1'b0;
  cfg_idx_t cfg_idx_i   = CfgFixFirst;
  reg_num_t cfg_wdata_i = '0;

  reg_pick_scoreboard sb;

  round_robin_free_register_picker_top u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .action_i       (action_i),
    .busy_mask_i    (busy_mask_i),
    .result_valid_o (result_valid_o),
    .chosen_reg_o   (chosen_reg_o),
    .failed_o       (failed_o),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_wdata_i    (cfg_wdata_i)
  );

  // Clock with a 10 ns period.
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Every strobed result is checked at the edge that ends its cycle.
  always @(posedge clk_i) begin
    if (rst_ni && result_valid_o) sb.check_pick(chosen_reg_o, failed_o);
  end

  // Present an item and hold it until the block takes it; start stays high afterwards.
  task automatic send_item(input action_t act, input mask_t mask);
    start       <= 1'b1;
    action_i    <= act;
    busy_mask_i <= mask;
    do @(posedge clk_i); while (busy);
    sb.predict_pick(act, mask);
  endtask

  // Idle the request side for a random run of cycles, each with the given chance.
  task automatic idle_gap(input int pct);
    if ($urandom_range(0, 99) < pct) begin
      start <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(0, 99) < pct);
    end
  endtask

  // Stop requesting and wait until every pick is back and the block has gone quiet.
  task automatic settle();
    start <= 1'b0;
    while (sb.pending() != 0 || busy) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic write_one(input cfg_idx_t idx, input reg_num_t val);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    sb.write_reg(idx, val);
  endtask

  // Load the whole register numbering, one register per cycle.
  task automatic program_registers(input reg_num_t ff, input reg_num_t fl, input reg_num_t fr,
                                   input reg_num_t hb, input reg_num_t fail,
                                   input reg_num_t lf, input reg_num_t ll);
    write_one(CfgFixFirst, ff);
    write_one(CfgFixLast, fl);
    write_one(CfgFixRestart, fr);
    write_one(CfgHeldBack, hb);
    write_one(CfgFixFail, fail);
    write_one(CfgFltFirst, lf);
    write_one(CfgFltLast, ll);
    cfg_we_i <= 1'b0;
  endtask

  // Masks lean towards crowded files so that scans run long and often fail.
  function automatic mask_t rand_mask();
    mask_t m;
    case ($urandom_range(0, 7))
      0: m = $urandom();
      1: m = $urandom() & $urandom() & $urandom();
      2: m = $urandom() | $urandom() | $urandom();
      3: m = '1;
      4: m = ~(mask_t'(1) << $urandom_range(0, 31));
      5: m = ~((mask_t'(1) << $urandom_range(0, 31)) | (mask_t'(1) << $urandom_range(0, 31)));
      6: m = '0;
      default: m = $urandom() | $urandom();
    endcase
    return m;
  endfunction

  function automatic action_t rand_action();
    int roll;
    action_t act;
    roll = $urandom_range(0, 99);
    if (roll < 6) begin
      act = ActStart;
    end else if (roll < 9) begin
      act = ActUnused;
    end else if (roll < 55) begin
      act = ActFixed;
    end else begin
      act = ActFloat;
    end
    return act;
  endfunction

  // Main sequence: reset, directed items, then random phases over several numberings.
  initial begin
    int idle_pct;
    sb = new();
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed items under the reset numbering.
    send_item(ActFixed, '0);
    send_item(ActFloat, '0);
    send_item(ActFixed, '1);
    send_item(ActFloat, '1);
    send_item(ActFixed, ~(mask_t'(1) << 15));
    send_item(ActFixed, ~((mask_t'(1) << 15) | (mask_t'(1) << 16)));
    send_item(ActFloat, 32'h7FFF_FFFF);
    send_item(ActFloat, 32'hFFFF_FFFE);
    // Only register zero free: outside the fixed ring and the held-back one is busy.
    send_item(ActFixed, 32'hFFFF_FFFE);
    send_item(ActUnused, '0);
    send_item(ActStart, 32'h1234_5678);
    send_item(ActFixed, '0);
    send_item(ActFloat, '0);
    send_item(ActFixed, 32'h8000_0000);
    send_item(ActFixed, 32'h7FFF_FFFF);
    send_item(ActFloat, 32'h5555_5555);
    send_item(ActFixed, 32'hAAAA_AAAA);
    send_item(ActUnused, '1);
    send_item(ActStart, '1);
    send_item(ActFixed, 32'hFFFF_7FFF);

    // Random phases; the numbering changes only once the block is quiet.
    for (int phase = 0; phase < 8; phase++) begin
      settle();
      case (phase)
        0: ;
        1: program_registers(5'd0, 5'd31, 5'd0, 5'd0, 5'd31, 5'd0, 5'd31);
        // Small rings with a restart value that lies off the fixed ring.
        2: program_registers(5'd4, 5'd7, 5'd20, 5'd5, 5'd0, 5'd10, 5'd12);
        // First above last: the rings wrap through the top of the numbering.
        3: program_registers(5'd31, 5'd0, 5'd31, 5'd31, 5'd31, 5'd31, 5'd0);
        // One-register rings, the fixed one being the held-back register itself.
        4: program_registers(5'd16, 5'd16, 5'd16, 5'd16, 5'd16, 5'd0, 5'd0);
        default: program_registers(reg_num_t'($urandom_range(0, 31)),
                                   reg_num_t'($urandom_range(0, 31)),
                                   reg_num_t'($urandom_range(0, 31)),
                                   reg_num_t'($urandom_range(0, 31)),
                                   reg_num_t'($urandom_range(0, 31)),
                                   reg_num_t'($urandom_range(0, 31)),
                                   reg_num_t'($urandom_range(0, 31)));
      endcase
      case (phase % 3)
        0: idle_pct = 0;
        1: idle_pct = 81;
        default: idle_pct = 18;
      endcase
      repeat (125) begin
        idle_gap(idle_pct);
        send_item(rand_action(), rand_mask());
      end
    end

    settle();
    if (sb.failures == 0 && sb.pending() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  // Guard against a hang.
  initial begin
    #5ms;
    $display("TB_ERROR");
    $finish;
  end

endmodule
